>>> src/lpg_pkg.sv
// Shared types, constants and helper functions for the LED pattern generator.
package lpg_pkg;

  typedef enum logic [3:0] {
    MODE_BIN_UP   = 4'd0,
    MODE_BIN_DOWN = 4'd1,
    MODE_GRAY_UP  = 4'd2,
    MODE_GRAY_DN  = 4'd3,
    MODE_BCD_UP   = 4'd4,
    MODE_BCD_DOWN = 4'd5,
    MODE_BOUNCE   = 4'd6,
    MODE_ROTATE   = 4'd7,
    MODE_SHIFT    = 4'd8
  } mode_t;

  localparam logic [7:0] SEED_RESET = 8'd57;
  localparam logic [7:0] BCD_MAX    = 8'd99;
  localparam logic [7:0] ROT_INIT   = 8'h01;
  localparam logic [2:0] POS_TOP    = 3'd7;
  localparam logic [2:0] POS_BOTTOM = 3'd0;

  // Tens are found by a reciprocal multiply, which is exact for all 8-bit values.
  function automatic logic [7:0] bcd_of(input logic [7:0] v);
    logic [18:0] prod;
    logic [4:0]  tens;
    logic [7:0]  tens10;
    logic [7:0]  ones;
    prod   = {11'd0, v} * 19'd205;
    tens   = prod[15:11];
    tens10 = {tens, 3'b000} + {2'b00, tens, 1'b0};
    ones   = v - tens10;
    return {tens[3:0], ones[3:0]};
  endfunction

endpackage

>>> src/led_pattern_generator.sv
// LED pattern generator top level with state and result registers.
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid/in_ready, button start/end samples  | input
//  out     | out_valid/out_ready, led pattern, shown mode | output
//  cfg     | cfg_we, cfg_wdata (shift seed)               | input
//
// The pattern and next state of an item are computed in one pass from the mode and
// pattern registers; the pattern lands in the result register.
// A new item is taken every cycle while the result register is empty or drained.
// Synchronous active-low reset presets the mode, all pattern state and the seed.
// A stalled result holds, and the input is refused until it is taken.
module led_pattern_generator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_next_start,
  input  logic       in_next_end,
  input  logic       in_back_start,
  input  logic       in_back_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_led_pattern,
  output logic [3:0] out_shown_mode,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  lpg_pkg::mode_t mode_r, mode_nxt, mode_step;
  logic [7:0] seed_r;
  logic [7:0] count_r, count_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic       down_r, down_nxt;
  logic [7:0] rot_r, rot_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       out_valid_r;
  logic [7:0] out_led_r, led_nxt;
  logic [3:0] out_mode_r;
  logic       in_acc;
  logic       next_edge, back_edge;

  assign in_ready        = !out_valid_r || out_ready;
  assign in_acc          = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_led_pattern = out_led_r;
  assign out_shown_mode  = out_mode_r;
  assign next_edge       = !in_next_start && in_next_end;
  assign back_edge       = !in_back_start && in_back_end;

  always_comb begin
    led_nxt   = 8'd0;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    down_nxt  = down_r;
    rot_nxt   = rot_r;
    shift_nxt = shift_r;
    unique case (mode_r)
      lpg_pkg::MODE_BIN_UP: begin
        led_nxt   = count_r;
        count_nxt = count_r + 8'd1;
      end
      lpg_pkg::MODE_BIN_DOWN: begin
        led_nxt   = count_r;
        count_nxt = count_r - 8'd1;
      end
      lpg_pkg::MODE_GRAY_UP: begin
        led_nxt   = count_r ^ {1'b0, count_r[7:1]};
        count_nxt = count_r + 8'd1;
      end
      lpg_pkg::MODE_GRAY_DN: begin
        led_nxt   = count_r ^ {1'b0, count_r[7:1]};
        count_nxt = count_r - 8'd1;
      end
      lpg_pkg::MODE_BCD_UP: begin
        led_nxt   = lpg_pkg::bcd_of(count_r);
        count_nxt = (count_r + 8'd1 > lpg_pkg::BCD_MAX) ? 8'd0 : count_r + 8'd1;
      end
      lpg_pkg::MODE_BCD_DOWN: begin
        led_nxt   = lpg_pkg::bcd_of(count_r);
        count_nxt = (count_r == 8'd0) ? lpg_pkg::BCD_MAX : count_r - 8'd1;
      end
      lpg_pkg::MODE_BOUNCE: begin
        led_nxt = 8'd1 << pos_r;
        pos_nxt = down_r ? pos_r - 3'd1 : pos_r + 3'd1;
        if (pos_nxt == lpg_pkg::POS_TOP || pos_nxt == lpg_pkg::POS_BOTTOM) begin
          down_nxt = !down_r;
        end
      end
      lpg_pkg::MODE_ROTATE: begin
        led_nxt = rot_r;
        rot_nxt = (rot_r[6:0] == 7'd0) ? lpg_pkg::ROT_INIT : {rot_r[6:0], 1'b0};
      end
      lpg_pkg::MODE_SHIFT: begin
        shift_nxt = {shift_r[6:0], shift_r[5] ^ shift_r[4]};
        led_nxt   = shift_nxt;
      end
      default: begin
        led_nxt = 8'd0;
      end
    endcase

    mode_step = mode_r;
    if (next_edge) begin
      mode_step = (mode_r >= lpg_pkg::MODE_SHIFT) ? lpg_pkg::MODE_BIN_UP
                                                   : lpg_pkg::mode_t'(mode_r + 4'd1);
    end
    mode_nxt = mode_step;
    if (back_edge) begin
      mode_nxt = (mode_step == lpg_pkg::MODE_BIN_UP) ? lpg_pkg::MODE_SHIFT
                                                       : lpg_pkg::mode_t'(mode_step - 4'd1);
    end
    if (next_edge || back_edge) begin
      count_nxt = 8'd0;
      pos_nxt   = 3'd0;
      down_nxt  = 1'b0;
      rot_nxt   = lpg_pkg::ROT_INIT;
      shift_nxt = seed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= lpg_pkg::SEED_RESET;
      mode_r      <= lpg_pkg::MODE_BIN_UP;
      count_r     <= 8'd0;
      pos_r       <= 3'd0;
      down_r      <= 1'b0;
      rot_r       <= lpg_pkg::ROT_INIT;
      shift_r     <= lpg_pkg::SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
      if (in_acc) begin
        mode_r  <= mode_nxt;
        count_r <= count_nxt;
        pos_r   <= pos_nxt;
        down_r  <= down_nxt;
        rot_r   <= rot_nxt;
        shift_r <= shift_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_led_r  <= led_nxt;
      out_mode_r <= mode_r;
    end
  end

endmodule

>>> src/lpg_checker.sv
// Port-level assertions for the LED pattern generator and their bind.
module lpg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_led_pattern,
  input logic [3:0] out_shown_mode
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_led_pattern)
                                && $stable(out_shown_mode))
    else $error("Stalled result item changed.");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("Accepted item produced no result.");

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_shown_mode <= 4'(lpg_pkg::MODE_SHIFT))
    else $error("Shown mode out of range.");

  a_single_light: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_shown_mode == 4'(lpg_pkg::MODE_BOUNCE)
               || out_shown_mode == 4'(lpg_pkg::MODE_ROTATE)) |-> $onehot(out_led_pattern))
    else $error("Single-light mode shows other than one lit bit.");

endmodule

bind led_pattern_generator lpg_checker u_lpg_checker (.*);

>>> dv/testbench.sv
// Self-checking testbench for the LED pattern generator: directed table, random ticks, predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 300;
  localparam int SEGMENT_TICKS = 275;

  typedef struct packed {
    logic       ns;
    logic       ne;
    logic       bs;
    logic       be;
    logic       typed;
    logic [7:0] led;
    logic [3:0] mode;
  } tick_t;

  typedef struct packed {
    logic [7:0] led;
    logic [3:0] mode;
  } pattern_t;

  localparam tick_t DIRECTED_TICKS [25] = '{
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00, lpg_pkg::MODE_BIN_UP},
    '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'h01, lpg_pkg::MODE_BIN_UP},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'h02, lpg_pkg::MODE_BIN_UP},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00, lpg_pkg::MODE_BIN_DOWN},
    '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 8'hff, lpg_pkg::MODE_BIN_DOWN},
    '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 8'hfe, lpg_pkg::MODE_BIN_DOWN},
    '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00, lpg_pkg::MODE_GRAY_UP},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'h01, lpg_pkg::MODE_GRAY_UP},
    '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00, lpg_pkg::MODE_GRAY_DN},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h80, lpg_pkg::MODE_GRAY_DN},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, lpg_pkg::MODE_GRAY_DN},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00, lpg_pkg::MODE_BCD_UP},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00, lpg_pkg::MODE_BCD_DOWN},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h99, lpg_pkg::MODE_BCD_DOWN},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, lpg_pkg::MODE_BCD_DOWN},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h01, lpg_pkg::MODE_BOUNCE},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, lpg_pkg::MODE_BOUNCE},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h01, lpg_pkg::MODE_ROTATE},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, lpg_pkg::MODE_ROTATE},
    '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h72, lpg_pkg::MODE_SHIFT},
    '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, lpg_pkg::MODE_SHIFT},
    '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, lpg_pkg::MODE_BIN_UP},
    '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'h72, lpg_pkg::MODE_SHIFT},
    '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 8'h72, lpg_pkg::MODE_SHIFT},
    '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, lpg_pkg::MODE_SHIFT}
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_next_start;
  logic       in_next_end;
  logic       in_back_start;
  logic       in_back_end;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_led_pattern;
  logic [3:0] out_shown_mode;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  logic       in_typed;
  logic [7:0] in_typed_led;
  logic [3:0] in_typed_mode;

  lpg_pkg::mode_t cur_mode;
  logic [7:0] tick_count;
  logic [2:0] light_pos;
  logic       light_down;
  logic [7:0] rot_bit;
  logic [7:0] shift_reg;
  logic [7:0] seed_reg;

  pattern_t   pattern_q[$];
  pattern_t   got_pattern;
  pattern_t   want_pattern;
  int         error_count;
  int         cycle_count;
  int         tx_idle_pct;
  int         rx_idle_pct;
  int         hold_left;
  logic       hold_request;

  led_pattern_generator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_next_start   (in_next_start),
    .in_next_end     (in_next_end),
    .in_back_start   (in_back_start),
    .in_back_end     (in_back_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_led_pattern (out_led_pattern),
    .out_shown_mode  (out_shown_mode),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic void clear_patterns();
    tick_count = 8'd0;
    light_pos = lpg_pkg::POS_BOTTOM;
    light_down = 1'b0;
    rot_bit = lpg_pkg::ROT_INIT;
    shift_reg = seed_reg;
  endfunction

  function automatic pattern_t render_tick(input logic ns, input logic ne, input logic bs,
                                           input logic be);
    pattern_t   res;
    logic [7:0] tens;
    logic [7:0] ones;
    logic       feedback;
    res.mode = cur_mode;
    res.led = 8'd0;
    tens = tick_count / 8'd10;
    ones = tick_count % 8'd10;
    case (cur_mode)
      lpg_pkg::MODE_BIN_UP: begin
        res.led = tick_count;
        tick_count = tick_count + 8'd1;
      end
      lpg_pkg::MODE_BIN_DOWN: begin
        res.led = tick_count;
        tick_count = tick_count - 8'd1;
      end
      lpg_pkg::MODE_GRAY_UP: begin
        res.led = tick_count ^ (tick_count >> 1);
        tick_count = tick_count + 8'd1;
      end
      lpg_pkg::MODE_GRAY_DN: begin
        res.led = tick_count ^ (tick_count >> 1);
        tick_count = tick_count - 8'd1;
      end
      lpg_pkg::MODE_BCD_UP: begin
        res.led = {tens[3:0], ones[3:0]};
        tick_count = tick_count + 8'd1;
        if (tick_count > lpg_pkg::BCD_MAX) tick_count = 8'd0;
      end
      lpg_pkg::MODE_BCD_DOWN: begin
        res.led = {tens[3:0], ones[3:0]};
        tick_count = (tick_count == 8'd0) ? lpg_pkg::BCD_MAX : tick_count - 8'd1;
      end
      lpg_pkg::MODE_BOUNCE: begin
        res.led = 8'd1 << light_pos;
        light_pos = light_down ? light_pos - 3'd1 : light_pos + 3'd1;
        if (light_pos == lpg_pkg::POS_TOP || light_pos == lpg_pkg::POS_BOTTOM)
          light_down = ~light_down;
      end
      lpg_pkg::MODE_ROTATE: begin
        res.led = rot_bit;
        rot_bit = rot_bit << 1;
        if (rot_bit == 8'd0) rot_bit = lpg_pkg::ROT_INIT;
      end
      lpg_pkg::MODE_SHIFT: begin
        feedback = shift_reg[5] ^ shift_reg[4];
        shift_reg = {shift_reg[6:0], feedback};
        res.led = shift_reg;
      end
      default: res.led = 8'd0;
    endcase
    if (!ns && ne) begin
      cur_mode = (cur_mode >= lpg_pkg::MODE_SHIFT) ? lpg_pkg::MODE_BIN_UP
                                                   : lpg_pkg::mode_t'(cur_mode + 4'd1);
      clear_patterns();
    end
    if (!bs && be) begin
      cur_mode = (cur_mode == lpg_pkg::MODE_BIN_UP) ? lpg_pkg::MODE_SHIFT
                                                    : lpg_pkg::mode_t'(cur_mode - 4'd1);
      clear_patterns();
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) seed_reg = cfg_wdata;
      if (out_valid && out_ready) begin
        if (pattern_q.size() == 0) begin
          report_mismatch("result with no item pending", out_led_pattern, -1);
        end else begin
          want_pattern = pattern_q.pop_front();
          if (out_led_pattern !== want_pattern.led)
            report_mismatch("led_pattern", out_led_pattern, want_pattern.led);
          if (out_shown_mode !== want_pattern.mode)
            report_mismatch("shown_mode", out_shown_mode, want_pattern.mode);
        end
      end
      if (in_valid && in_ready) begin
        got_pattern = render_tick(in_next_start, in_next_end, in_back_start, in_back_end);
        if (in_typed) got_pattern = '{led: in_typed_led, mode: in_typed_mode};
        pattern_q.push_back(got_pattern);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic offer_item(input tick_t t);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_next_start <= t.ns;
    in_next_end <= t.ne;
    in_back_start <= t.bs;
    in_back_end <= t.be;
    in_typed <= t.typed;
    in_typed_led <= t.led;
    in_typed_mode <= t.mode;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pattern_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_seed(input logic [7:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [1:0] quiet_pair();
    int pick;
    pick = $urandom_range(0, 2);
    return (pick == 0) ? 2'b00 : (pick == 1) ? 2'b10 : 2'b11;
  endfunction

  initial begin
    tick_t      row;
    int         run_left;
    int         kind;
    logic       long_run;
    logic [1:0] next_pair;
    logic [1:0] back_pair;
    logic [7:0] seed_value;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_next_start = 1'b0;
    in_next_end = 1'b0;
    in_back_start = 1'b0;
    in_back_end = 1'b0;
    in_typed = 1'b0;
    in_typed_led = 8'd0;
    in_typed_mode = lpg_pkg::MODE_BIN_UP;
    cfg_we = 1'b0;
    cfg_wdata = 8'd0;
    out_ready = 1'b0;
    error_count = 0;
    cycle_count = 0;
    hold_left = 0;
    hold_request = 1'b0;
    tx_idle_pct = 15;
    rx_idle_pct = 58;
    seed_reg = lpg_pkg::SEED_RESET;
    cur_mode = lpg_pkg::MODE_BIN_UP;
    clear_patterns();
    run_left = 0;
    long_run = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_TICKS[i]) offer_item(DIRECTED_TICKS[i]);

    for (int seg = 0; seg < 6; seg++) begin
      settle_idle();
      seed_value = (seg == 0) ? 8'd255 : (seg == 1) ? 8'd1 : (seg == 2) ? 8'd0 :
                   8'($urandom_range(1, 255));
      write_seed(seed_value);
      case (seg % 3)
        0: begin
          tx_idle_pct = 15;
          rx_idle_pct = 58;
        end
        1: begin
          tx_idle_pct = 58;
          rx_idle_pct = 15;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < SEGMENT_TICKS; k++) begin
        row = '0;
        if (!long_run && $urandom_range(0, 7) == 0) begin
          {row.ns, row.ne, row.bs, row.be} = 4'($urandom_range(0, 15));
          if (run_left != 0) run_left--;
        end else if (run_left != 0) begin
          run_left--;
          {row.ns, row.ne} = quiet_pair();
          {row.bs, row.be} = quiet_pair();
        end else begin
          kind = $urandom_range(0, 9);
          next_pair = (kind <= 5 || kind == 9) ? 2'b01 : quiet_pair();
          back_pair = (kind >= 6) ? 2'b01 : quiet_pair();
          {row.ns, row.ne, row.bs, row.be} = {next_pair, back_pair};
          long_run = ($urandom_range(0, 5) == 0);
          run_left = long_run ? $urandom_range(150, 300) : $urandom_range(0, 30);
        end
        if (run_left == 0) long_run = 1'b0;
        offer_item(row);
        if (seg == 0 && k == 60) hold_request = 1'b1;
      end
    end

    settle_idle();
    repeat (10) @(negedge clk);
    if (error_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
